/* hdl/point_in_polygon_even_odd_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-polygon core
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_EVEN_ODD_CORE_MACROS_SVH
`define POINT_IN_POLYGON_EVEN_ODD_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PIP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/pip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared codes, control words and state type of the point-in-polygon core.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Word mode codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Cells in the multiply chain; each takes one digit of the multiplier
    localparam int unsigned NUM_CELLS = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

    // Tag that travels with a vertex read
    typedef struct packed {
        logic vld;
        logic has_prev;
        logic last;
    } t_rd_ctl;

    // Tag that travels with an edge through the cell chain
    typedef struct packed {
        logic vld;
        logic last;
        logic skip;
    } t_tok_ctl;

endpackage

/* hdl/pip_vstore.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_vstore
// Vertex memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pip_vstore #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int CB    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [CB-1:0] i_wx,
    input  logic signed [CB-1:0] i_wy,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [CB-1:0] o_rx,
    output logic signed [CB-1:0] o_ry
);

    logic signed [CB-1:0] mem_x [0:DEPTH-1];
    logic signed [CB-1:0] mem_y [0:DEPTH-1];
    logic signed [CB-1:0] r_rx;
    logic signed [CB-1:0] r_ry;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_x[i_waddr] <= i_wx;
            mem_y[i_waddr] <= i_wy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rx <= mem_x[i_raddr];
            r_ry <= mem_y[i_raddr];
        end
    end

    assign o_rx = r_rx;
    assign o_ry = r_ry;

endmodule

/* hdl/pip_edge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge
// Pair each vertex with the one read before it, test the edge against the
// point's y and form the operands of the exact crossing compare.
// ----------------------------------------------------------------------------
module pip_edge #(
    parameter int CB    = 32,
    parameter int DBITS = 33,
    parameter int PW    = 33
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pip_pkg::t_rd_ctl        i_ctl,
    input  logic signed [CB-1:0]    i_vx,
    input  logic signed [CB-1:0]    i_vy,
    input  logic signed [CB-1:0]    i_qx,
    input  logic signed [CB-1:0]    i_qy,
    output pip_pkg::t_tok_ctl       o_ctl,
    output logic signed [DBITS-1:0] o_a,
    output logic signed [PW-1:0]    o_b,
    output logic signed [DBITS-1:0] o_c,
    output logic signed [PW-1:0]    o_d
);

    import pip_pkg::*;

    logic signed [CB-1:0]    r_ex;
    logic signed [CB-1:0]    r_ey;
    t_tok_ctl                r_ctl;
    logic signed [DBITS-1:0] r_a;
    logic signed [DBITS-1:0] r_c;
    logic signed [PW-1:0]    r_b;
    logic signed [PW-1:0]    r_d;

    logic                    w_skip;
    logic                    w_pos;
    logic signed [DBITS-1:0] w_dx;
    logic signed [DBITS-1:0] w_dy;
    logic signed [DBITS-1:0] w_rx;
    logic signed [DBITS-1:0] w_ry;

    // Edge counts only when exactly one end lies above the point
    assign w_skip = ((i_vy > i_qy) == (r_ey > i_qy));

    assign w_dx = DBITS'(r_ex) - DBITS'(i_vx);
    assign w_dy = DBITS'(r_ey) - DBITS'(i_vy);
    assign w_rx = DBITS'(i_qx) - DBITS'(i_vx);
    assign w_ry = DBITS'(i_qy) - DBITS'(i_vy);
    assign w_pos = ~w_dy[DBITS-1] && (w_dy != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.vld  <= i_ctl.vld & i_ctl.has_prev;
            r_ctl.last <= i_ctl.last;
            r_ctl.skip <= w_skip;
        end
    end

    // Hit when a*b - c*d is negative; swap the products when dy is not positive
    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_ex <= i_vx;
            r_ey <= i_vy;
        end
        if (w_pos) begin
            r_a <= w_rx;
            r_b <= PW'(w_dy);
            r_c <= w_ry;
            r_d <= PW'(w_dx);
        end else begin
            r_a <= w_ry;
            r_b <= PW'(w_dx);
            r_c <= w_rx;
            r_d <= PW'(w_dy);
        end
    end

    assign o_ctl = r_ctl;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_c   = r_c;
    assign o_d   = r_d;

endmodule

/* hdl/pip_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_cell
// One cell of the product-difference chain: add one digit's share of
// a*b - c*d to the running sum and pass everything to the next cell.
// ----------------------------------------------------------------------------
module pip_cell #(
    parameter int DBITS = 33,
    parameter int PW    = 33,
    parameter int CW    = 11,
    parameter int ACCW  = 68,
    parameter int SHIFT = 0,
    parameter bit TOP   = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pip_pkg::t_tok_ctl       i_ctl,
    input  logic signed [DBITS-1:0] i_a,
    input  logic signed [PW-1:0]    i_b,
    input  logic signed [DBITS-1:0] i_c,
    input  logic signed [PW-1:0]    i_d,
    input  logic signed [ACCW-1:0]  i_acc,
    output pip_pkg::t_tok_ctl       o_ctl,
    output logic signed [DBITS-1:0] o_a,
    output logic signed [PW-1:0]    o_b,
    output logic signed [DBITS-1:0] o_c,
    output logic signed [PW-1:0]    o_d,
    output logic signed [ACCW-1:0]  o_acc
);

    import pip_pkg::*;

    logic signed [CW:0]       w_bk;
    logic signed [CW:0]       w_dk;
    logic signed [DBITS+CW:0] w_pb;
    logic signed [DBITS+CW:0] w_pd;
    logic signed [ACCW-1:0]   n_acc;

    t_tok_ctl                 r_ctl;
    logic signed [DBITS-1:0]  r_a;
    logic signed [PW-1:0]     r_b;
    logic signed [DBITS-1:0]  r_c;
    logic signed [PW-1:0]     r_d;
    logic signed [ACCW-1:0]   r_acc;

    // Lower digits are unsigned, the top digit carries the sign
    assign w_bk = $signed({(TOP ? i_b[SHIFT+CW-1] : 1'b0), i_b[SHIFT +: CW]});
    assign w_dk = $signed({(TOP ? i_d[SHIFT+CW-1] : 1'b0), i_d[SHIFT +: CW]});
    assign w_pb = i_a * w_bk;
    assign w_pd = i_c * w_dk;
    assign n_acc = i_acc + (ACCW'(w_pb) <<< SHIFT) - (ACCW'(w_pd) <<< SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= i_a;
        r_b   <= i_b;
        r_c   <= i_c;
        r_d   <= i_d;
        r_acc <= n_acc;
    end

    assign o_ctl = r_ctl;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_c   = r_c;
    assign o_d   = r_d;
    assign o_acc = r_acc;

endmodule

/* hdl/point_in_polygon_even_odd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_even_odd_core
// Load words leave busy low, so the next word may follow without a wait.
// A query over n stored vertices reads one vertex per cycle, holds busy until the
// last edge leaves the cell chain and strobes its result as busy falls.
// A query on an empty polygon strobes its result in the next cycle.
// Synchronous active-low reset empties the polygon and clears the overflow
// flag; vertex memory contents are not cleared.
// ----------------------------------------------------------------------------
module point_in_polygon_even_odd_core #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic        i_first,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic        o_valid,
    output logic        o_inside_res,
    output logic        o_truncated
);

    import pip_pkg::*;

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int DBITS = COORD_BITS + 1;
    localparam int CW    = (DBITS + NUM_CELLS - 1) / NUM_CELLS;
    localparam int PW    = NUM_CELLS * CW;
    localparam int ACCW  = 2 * DBITS + 2;

    // Control state
    t_state   r_state;
    t_state   n_state;
    logic [NW-1:0] r_count;
    logic [NW-1:0] n_count;
    logic          r_ovf;
    logic          n_ovf;
    logic [NW-1:0] r_k;
    logic [NW-1:0] n_k;
    t_rd_ctl       r_rdc;
    t_rd_ctl       n_rdc;
    logic          r_par;
    logic          r_out_v;

    // Payload
    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] r_qy;
    logic                         r_inside;
    logic                         r_trunc;

    // Handshake and load decode
    logic          w_accept;
    logic          w_load;
    logic          w_query;
    logic          w_q_empty;
    logic          w_q_walk;
    logic [NW-1:0] w_base;
    logic          w_full;
    logic          w_we;

    // Read sequencer
    logic          w_re;
    logic [NW-1:0] w_idx;
    logic [AW-1:0] w_raddr;

    logic signed [COORD_BITS-1:0] w_cx;
    logic signed [COORD_BITS-1:0] w_cy;
    logic signed [COORD_BITS-1:0] w_vx;
    logic signed [COORD_BITS-1:0] w_vy;

    // Cell chain taps
    t_tok_ctl                w_ctl [0:NUM_CELLS];
    logic signed [DBITS-1:0] w_a   [0:NUM_CELLS];
    logic signed [PW-1:0]    w_b   [0:NUM_CELLS];
    logic signed [DBITS-1:0] w_c   [0:NUM_CELLS];
    logic signed [PW-1:0]    w_d   [0:NUM_CELLS];
    logic signed [ACCW-1:0]  w_acc [0:NUM_CELLS];

    logic w_hit;
    logic w_done;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start & ~busy;
    assign w_load   = w_accept && (i_mode == MODE_LOAD);
    assign w_query  = w_accept && (i_mode == MODE_QUERY);
    assign w_q_empty = w_query && (r_count == '0);
    assign w_q_walk  = w_query && (r_count != '0);

    // Coordinates are the low COORD_BITS of the word, taken as signed
    assign w_cx = i_x[COORD_BITS-1:0];
    assign w_cy = i_y[COORD_BITS-1:0];

    // Load: a first word restarts the polygon; a full store drops the vertex
    assign w_base = i_first ? '0 : r_count;
    assign w_full = (w_base == NW'(MAX_VERTICES));
    assign w_we   = w_load & ~w_full;

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (w_load) begin
            if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = w_base + 1'b1;
                if (i_first) begin
                    n_ovf = 1'b0;
                end
            end
        end
    end

    // Walk order: last vertex first, then 0 .. n-1, so each read after the
    // first closes the edge to the vertex read before it.
    assign w_idx   = (r_k == '0) ? (r_count - 1'b1) : (r_k - 1'b1);
    assign w_raddr = w_idx[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        w_re    = 1'b0;
        n_rdc   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_q_walk) begin
                    n_state = ST_WALK;
                    n_k     = '0;
                end
            end
            ST_WALK: begin
                w_re           = 1'b1;
                n_rdc.vld      = 1'b1;
                n_rdc.has_prev = (r_k != '0);
                n_rdc.last     = (r_k == r_count);
                n_k            = r_k + 1'b1;
                if (r_k == r_count) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // hold until the last edge leaves the chain
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    pip_vstore #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW),
        .CB    (COORD_BITS)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_base[AW-1:0]),
        .i_wx    (w_cx),
        .i_wy    (w_cy),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rx    (w_vx),
        .o_ry    (w_vy)
    );

    pip_edge #(
        .CB    (COORD_BITS),
        .DBITS (DBITS),
        .PW    (PW)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rdc),
        .i_vx    (w_vx),
        .i_vy    (w_vy),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_ctl   (w_ctl[0]),
        .o_a     (w_a[0]),
        .o_b     (w_b[0]),
        .o_c     (w_c[0]),
        .o_d     (w_d[0])
    );

    assign w_acc[0] = '0;

    // Each cell folds in one digit of the multipliers
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        pip_cell #(
            .DBITS (DBITS),
            .PW    (PW),
            .CW    (CW),
            .ACCW  (ACCW),
            .SHIFT (g * CW),
            .TOP   (g == NUM_CELLS - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_a     (w_a[g]),
            .i_b     (w_b[g]),
            .i_c     (w_c[g]),
            .i_d     (w_d[g]),
            .i_acc   (w_acc[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_a     (w_a[g+1]),
            .o_b     (w_b[g+1]),
            .o_c     (w_c[g+1]),
            .o_d     (w_d[g+1]),
            .o_acc   (w_acc[g+1])
        );
    end

    // A negative product difference means the crossing lies right of x
    assign w_hit  = w_ctl[NUM_CELLS].vld & ~w_ctl[NUM_CELLS].skip
                    & w_acc[NUM_CELLS][ACCW-1];
    assign w_done = w_ctl[NUM_CELLS].vld & w_ctl[NUM_CELLS].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_k     <= '0;
            r_rdc   <= '0;
            r_par   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_k     <= n_k;
            r_rdc   <= n_rdc;
            r_out_v <= w_q_empty | w_done;
            if (w_q_walk) begin
                r_par <= 1'b0;
            end else begin
                r_par <= r_par ^ w_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_qx <= w_cx;
            r_qy <= w_cy;
        end
        if (w_q_empty) begin
            r_inside <= 1'b0;
            r_trunc  <= r_ovf;
        end else if (w_done) begin
            r_inside <= r_par ^ w_hit;
            r_trunc  <= r_ovf;
        end
    end

    assign o_valid      = r_out_v;
    assign o_inside_res = r_inside;
    assign o_truncated  = r_trunc;

endmodule

/* hdl/pip_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks of the point-in-polygon core, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_in_polygon_even_odd_core_macros.svh"

module pip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_mode,
    input logic        o_valid
);

    import pip_pkg::*;

    // A load word never produces a result
    `PIP_ASSERT_NEXT(a_load_silent, start && !busy && i_mode == MODE_LOAD, !o_valid, "result after load word")

    // A query either starts a walk or answers at once
    `PIP_ASSERT_NEXT(a_query_moves, start && !busy && i_mode == MODE_QUERY, busy || o_valid, "query word dropped")

    // A result is only shown once the core is free again
    `PIP_ASSERT_SAME(a_result_idle, o_valid, !busy, "result strobe while busy")

    // Leaving a walk always delivers its result
    `PIP_ASSERT_SAME(a_walk_ends, $fell(busy), o_valid, "walk ended without result")

endmodule

bind point_in_polygon_even_odd_core pip_checker u_pip_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_mode  (i_mode),
    .o_valid (o_valid)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the even-odd point-in-polygon core. Polygons are
// loaded one vertex word at a time and probed with query words. A bit-exact
// model in the bench keeps its own vertex store and predicts every query
// verdict, which is compared field by field against the result strobe.
// ----------------------------------------------------------------------------
module tb;
    import pip_pkg::*;

    localparam int MAX_VERT   = 1024;
    localparam int RAND_WORDS = 550;
    localparam int TAIL_CALM  = 40;

    // Ranges for random coordinates: tiny ranges hit equal y values and
    // horizontal edges often, the extreme set stresses the wide products.
    typedef enum int {
        SC_TINY,
        SC_WIDE,
        SC_EXTREME,
        SC_FULL
    } t_coord_scale;

    typedef struct {
        logic        mode;
        logic        first;
        logic [31:0] x;
        logic [31:0] y;
        int unsigned gap;   // idle cycles after this word is taken
        bit          hold;  // wait for every verdict before offering it
    } t_poly_word;

    typedef struct packed {
        logic in_poly;
        logic trunc;
    } t_poly_verdict;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        i_mode  = 1'b0;
    logic        i_first = 1'b0;
    logic [31:0] i_x     = '0;
    logic [31:0] i_y     = '0;
    logic        busy;
    logic        o_valid;
    logic        o_inside_res;
    logic        o_truncated;

    point_in_polygon_even_odd_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_first     (i_first),
        .i_x         (i_x),
        .i_y         (i_y),
        .o_valid     (o_valid),
        .o_inside_res(o_inside_res),
        .o_truncated (o_truncated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Polygon model: own copy of the vertex store, count and drop flag
    // ------------------------------------------------------------------
    logic signed [31:0] vert_x [MAX_VERT];
    logic signed [31:0] vert_y [MAX_VERT];
    int unsigned        vert_cnt     = 0;
    bit                 vert_dropped = 1'b0;

    t_poly_word    word_q[$];     // words still to be offered
    t_poly_verdict verdict_q[$];  // verdicts owed by the core, oldest first
    t_poly_word    cur_word;
    t_poly_verdict drv_verdict;
    t_poly_verdict mon_want;
    int unsigned   gap_left   = 0;
    int unsigned   calm_left  = 0;
    int            errors     = 0;
    int            n_loads    = 0;
    int            n_queries  = 0;
    int            n_inside   = 0;
    int            n_trunc    = 0;

    // Apply one word to the model. Returns 1 when the word owes a verdict.
    function automatic bit poly_predict(input t_poly_word w, output t_poly_verdict v);
        logic signed [67:0] px, py, sx, sy, ex, ey, dx, dy, rx, ry;
        int unsigned        j;
        bit                 parity;
        bit                 hit;
        px     = $signed(w.x);
        py     = $signed(w.y);
        v      = '0;
        parity = 1'b0;
        if (w.mode == MODE_LOAD) begin
            if (w.first) begin
                vert_cnt     = 0;
                vert_dropped = 1'b0;
            end
            if (vert_cnt < MAX_VERT) begin
                vert_x[vert_cnt] = w.x;
                vert_y[vert_cnt] = w.y;
                vert_cnt++;
            end else begin
                vert_dropped = 1'b1;
            end
            return 1'b0;
        end
        // Walk each closing edge; vertex 0 pairs with the last vertex.
        for (int unsigned i = 0; i < vert_cnt; i++) begin
            j  = (i == 0) ? vert_cnt - 1 : i - 1;
            sx = vert_x[i];
            sy = vert_y[i];
            ex = vert_x[j];
            ey = vert_y[j];
            // Drop edges with both ends above, or both at or below, the point.
            if ((sy > py) == (ey > py))
                continue;
            dx = ex - sx;
            dy = ey - sy;
            rx = px - sx;
            ry = py - sy;
            // Crossing strictly right of x, compared exactly without a divide.
            hit    = (dy > 0) ? (rx * dy < ry * dx) : (ry * dx < rx * dy);
            parity = parity ^ hit;
        end
        v.in_poly = parity;
        v.trunc   = vert_dropped;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_coord(input t_coord_scale sc);
        case (sc)
            SC_TINY: return 32'($urandom_range(0, 32)) - 32'd16;
            SC_WIDE: return 32'($urandom_range(0, 2000000)) - 32'd1000000;
            SC_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Queue one word; idle gaps come in bursts, with calm stretches between.
    task automatic push_word(input logic mode, input logic first,
                             input logic [31:0] x, input logic [31:0] y);
        t_poly_word w;
        w.mode  = mode;
        w.first = first;
        w.x     = x;
        w.y     = y;
        w.hold  = 1'b0;
        if (calm_left != 0) begin
            calm_left--;
            w.gap = 0;
        end else begin
            if ($urandom_range(0, 9) == 0)
                calm_left = $urandom_range(10, 40);
            w.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        end
        word_q.push_back(w);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer words from the queue, predict on each accepted word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else begin
            // A word is taken when start is high and the core is not busy.
            if (start && !busy) begin
                if (poly_predict(cur_word, drv_verdict)) begin
                    verdict_q.push_back(drv_verdict);
                    n_queries++;
                end else begin
                    n_loads++;
                end
                gap_left = cur_word.gap;
            end
            // Hold the current word while it waits; otherwise pick the next.
            if (!start || !busy) begin
                if (gap_left != 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (word_q.size() != 0 &&
                             !(word_q[0].hold && verdict_q.size() != 0)) begin
                    cur_word = word_q.pop_front();
                    start   <= 1'b1;
                    i_mode  <= cur_word.mode;
                    i_first <= cur_word.first;
                    i_x     <= cur_word.x;
                    i_y     <= cur_word.y;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each strobed verdict against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (verdict_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected verdict, expected none, %s %0b %0b",
                         $time, "got inside/truncated", o_inside_res, o_truncated);
            end else begin
                mon_want = verdict_q.pop_front();
                if (o_inside_res !== mon_want.in_poly) begin
                    errors++;
                    $display("%0t: inside mismatch, expected %0b, got %0b",
                             $time, mon_want.in_poly, o_inside_res);
                end
                if (o_truncated !== mon_want.trunc) begin
                    errors++;
                    $display("%0t: truncated mismatch, expected %0b, got %0b",
                             $time, mon_want.trunc, o_truncated);
                end
                n_inside += o_inside_res;
                n_trunc  += o_truncated;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stim
        logic [31:0]  poly_x [80];
        logic [31:0]  poly_y [80];
        t_coord_scale sc;
        int unsigned  nv;
        int unsigned  nq;
        int unsigned  k;
        int unsigned  rand_base;
        logic [31:0]  qx;
        logic [31:0]  qy;

        // Empty polygon, and a query carrying a first flag that must be ignored.
        push_word(MODE_QUERY, 1'b0, 32'd0, 32'd0);
        push_word(MODE_QUERY, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Square of side 10: inside, outside, on each horizontal and vertical edge.
        push_word(MODE_LOAD, 1'b1, 32'd0,  32'd0);
        push_word(MODE_LOAD, 1'b0, 32'd10, 32'd0);
        push_word(MODE_LOAD, 1'b0, 32'd10, 32'd10);
        push_word(MODE_LOAD, 1'b0, 32'd0,  32'd10);
        push_word(MODE_QUERY, 1'b0, 32'd5,  32'd5);
        push_word(MODE_QUERY, 1'b0, 32'd15, 32'd5);
        push_word(MODE_QUERY, 1'b0, 32'd5,  32'd0);
        push_word(MODE_QUERY, 1'b0, 32'd5,  32'd10);
        push_word(MODE_QUERY, 1'b0, 32'd0,  32'd5);
        push_word(MODE_QUERY, 1'b0, 32'd10, 32'd5);
        push_word(MODE_QUERY, 1'b1, 32'd5,  32'd5);

        // Triangle spanning the full coordinate range.
        push_word(MODE_LOAD, 1'b1, 32'h8000_0000, 32'h8000_0000);
        push_word(MODE_LOAD, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        push_word(MODE_LOAD, 1'b0, 32'h0000_0000, 32'h7FFF_FFFF);
        push_word(MODE_QUERY, 1'b0, 32'h0000_0000, 32'h0000_0000);
        push_word(MODE_QUERY, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_word(MODE_QUERY, 1'b0, 32'h8000_0000, 32'h0000_0000);
        push_word(MODE_QUERY, 1'b0, 32'h0000_0000, 32'h8000_0000);

        // Degenerate one- and two-vertex polygons.
        push_word(MODE_LOAD, 1'b1, 32'd3, 32'd3);
        push_word(MODE_QUERY, 1'b0, 32'd0, 32'd3);
        push_word(MODE_LOAD, 1'b0, 32'd7, 32'd9);
        push_word(MODE_QUERY, 1'b0, 32'd1, 32'd5);

        // A first flag restarts the polygon; drain all verdicts before it.
        push_word(MODE_LOAD, 1'b1, 32'd0, 32'd0);
        word_q[$].hold = 1'b1;
        push_word(MODE_LOAD, 1'b0, 32'd8, 32'd0);
        push_word(MODE_LOAD, 1'b0, 32'd0, 32'd8);
        push_word(MODE_QUERY, 1'b0, 32'd1, 32'd1);

        // Random part: mostly whole polygons followed by probes, some noise.
        rand_base = word_q.size();
        while (word_q.size() - rand_base < RAND_WORDS) begin
            if ($urandom_range(0, 9) < 8) begin
                sc = t_coord_scale'($urandom_range(0, 3));
                case ($urandom_range(0, 19))
                    0:       nv = $urandom_range(1, 2);
                    1:       nv = $urandom_range(20, 80);
                    default: nv = $urandom_range(3, 12);
                endcase
                for (k = 0; k < nv; k++) begin
                    poly_x[k] = rand_coord(sc);
                    poly_y[k] = rand_coord(sc);
                    push_word(MODE_LOAD, k == 0, poly_x[k], poly_y[k]);
                    if (k == 0 && $urandom_range(0, 39) == 0)
                        word_q[$].hold = 1'b1;
                end
                nq = $urandom_range(1, 6);
                for (k = 0; k < nq; k++) begin
                    // Probe at vertex heights often to hit shared y values.
                    qx = ($urandom_range(0, 5) == 0) ? poly_x[$urandom_range(0, nv - 1)]
                                                     : rand_coord(sc);
                    qy = ($urandom_range(0, 2) == 0) ? poly_y[$urandom_range(0, nv - 1)]
                                                     : rand_coord(sc);
                    push_word(MODE_QUERY, 1'($urandom_range(0, 1)), qx, qy);
                end
            end else begin
                nq = $urandom_range(1, 4);
                for (k = 0; k < nq; k++)
                    push_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom(), $urandom());
            end
        end

        // No idling in the last stretch of the run.
        for (int t = word_q.size() - TAIL_CALM; t < word_q.size(); t++) begin
            word_q[t].gap  = 0;
            word_q[t].hold = 1'b0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Advance until every word is taken and every verdict has come.
        do
            @(negedge i_clk);
        while (word_q.size() != 0 || start || verdict_q.size() != 0);
        repeat (MAX_VERT + 16) @(negedge i_clk);

        if (verdict_q.size() != 0) begin
            errors += verdict_q.size();
            $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
        end
        $display("Run covered %0d vertex loads and %0d point queries,",
                 n_loads, n_queries);
        $display("with %0d verdicts inside and %0d flagged as truncated.",
                 n_inside, n_trunc);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Drop the run if the core stops answering.
    initial begin
        #30_000_000;
        $display("%0t: timeout", $time);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/pip_pkg.sv
hdl/pip_vstore.sv
hdl/pip_edge.sv
hdl/pip_cell.sv
hdl/point_in_polygon_even_odd_core.sv
hdl/pip_checker.sv
dv/tb.sv
